FILE: sv/lbpz_pkg.sv
// Shared types, constants and the code function of the 3x3 LBP block.
package lbpz_pkg;

    localparam int PIX_W          = 8;
    localparam int CODE_W         = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    // result queue: one code in the pipe plus two held covers the read latency
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // one line-memory entry: pixel two rows back (top) and one row back (mid)
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
    } col_t;

    // [row][column], row 0 on top, column 0 on the left
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic   valid;
        logic   is_pix;
        pixel_t pixel;
    } lm_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } res_t;

    // present[k] is 0 where neighbor k lies outside the image
    function automatic logic [CODE_W-1:0] lbp_code(input win_t w,
                                                   input logic [CODE_W-1:0] present);
        pixel_t            nb [CODE_W];
        pixel_t            ctr;
        logic [CODE_W-1:0] code;
        ctr   = w[1][1];
        nb[0] = w[0][0];
        nb[1] = w[0][1];
        nb[2] = w[0][2];
        nb[3] = w[1][2];
        nb[4] = w[2][2];
        nb[5] = w[2][1];
        nb[6] = w[2][0];
        nb[7] = w[1][0];
        for (int k = 0; k < CODE_W; k++) begin
            code[k] = present[k] & (nb[k] >= ctr);
        end
        return code;
    endfunction

endpackage

FILE: sv/lbp_code_zero_border_top.sv
// Top level of the streaming 3x3 local binary pattern coder with zero border.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   s_*      | s_tvalid / s_tready  | tdata[7:0] pixel, tuser[0] kind
//   m_*      | m_tvalid / m_tready  | tdata[7:0] code, tlast = final pixel
//   cfg_*    | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One word per clock on s_* while s_tready is high; codes pass stage 1 to reach m_*.
// The rate is set by the line memory: one column read and one write per clock.
// s_tready drops only when three codes are queued or in flight toward the queue.
// Reset (aresetn low, synchronous) clears counters and sets 640 x 480; the line
// memory is not cleared and needs no clearing pass. cfg_ready is always high.
module lbp_code_zero_border_top #(
    parameter int MAX_WIDTH  = lbpz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbpz_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input pixels
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lbpz_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    input  logic                              s_tuser,   // [0] kind: 0 pixel, 1 flush
    // result codes
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lbpz_pkg::CODE_W-1:0]       m_tdata,   // [7:0] code
    output logic                              m_tlast,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lbpz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbpz_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lbpz_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int CW = $clog2(MAX_WIDTH);       // column index
    localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
    localparam int RW = $clog2(MAX_HEIGHT);      // row index
    localparam int PW = $clog2(MAX_WIDTH + 3);   // pending count, up to width + 2
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    // ---------------- configuration ----------------
    logic [WW-1:0] eff_w_reg, eff_w_next;
    logic [HW-1:0] eff_h_reg, eff_h_next;
    logic [31:0]   w_raw, h_raw, w_clamp, h_clamp;
    logic          restart;

    assign cfg_ready = 1'b1;
    assign w_raw = 32'(cfg_data[CFG_WIDTH_BITS-1:0]);
    assign h_raw = 32'(cfg_data[CFG_HEIGHT_BITS-1:0]);

    always_comb begin
        if (w_raw < 32'd2)                  w_clamp = 32'd2;
        else if (w_raw > 32'(MAX_WIDTH))    w_clamp = 32'(MAX_WIDTH);
        else                                w_clamp = w_raw;
        if (h_raw < 32'd2)                  h_clamp = 32'd2;
        else if (h_raw > 32'(MAX_HEIGHT))   h_clamp = 32'(MAX_HEIGHT);
        else                                h_clamp = h_raw;

        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        restart    = 1'b0;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    eff_w_next = WW'(w_clamp);
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    eff_h_next = HW'(h_clamp);
                    restart    = 1'b1;
                end
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= WW'(RST_W);
            eff_h_reg <= HW'(RST_H);
        end else begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
        end
    end

    // ---------------- stage 0: positions and emit decision ----------------
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [PW-1:0] pending_reg, pending_next;

    logic          accept, is_pix, emit;
    logic [WW-1:0] w_m1;
    logic [HW-1:0] h_m1;
    logic [PW-1:0] w_p1, w_p2, need, pend_inc;
    logic          col_last, row_last, out_last, in_col_last;
    logic          has_top, has_bot, has_left, has_right;
    logic [CODE_W-1:0] mask;
    logic [CW-1:0] rd_addr;

    assign accept   = s_tvalid && s_tready;
    assign is_pix   = (s_tuser == KIND_PIXEL);
    assign w_m1     = eff_w_reg - WW'(1);
    assign h_m1     = eff_h_reg - HW'(1);
    assign w_p1     = PW'(eff_w_reg) + PW'(1);
    assign w_p2     = PW'(eff_w_reg) + PW'(2);
    assign pend_inc = pending_reg + PW'(1);

    // position of the oldest pending pixel, the next one to get its code
    assign col_last    = (WW'(out_col_reg) == w_m1);
    assign row_last    = (HW'(out_row_reg) == h_m1);
    assign out_last    = col_last && row_last;
    assign in_col_last = (WW'(in_col_reg) == w_m1);

    // neighbors inside the image; bit order matches the code bits
    assign has_top   = (out_row_reg != '0);
    assign has_bot   = !row_last;
    assign has_left  = (out_col_reg != '0);
    assign has_right = !col_last;
    assign mask = {has_left, has_bot & has_left, has_bot, has_bot & has_right,
                   has_right, has_top & has_right, has_top, has_top & has_left};

    // pending pixels a flush needs before it may code the oldest pending one
    always_comb begin
        if (row_last) need = col_last ? PW'(1) : PW'(2);
        else          need = col_last ? w_p1 : w_p2;
    end

    assign emit = accept && (is_pix ? (pend_inc >= w_p2) : (pending_reg >= need));

    // line memory column: a pixel goes to its own column; a flush fetches the
    // column right of the center, which then still holds the newer two rows
    assign rd_addr = is_pix ? in_col_reg
                   : (col_last ? '0 : out_col_reg + CW'(1));

    always_comb begin
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        if (restart) begin
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
        end else if (accept) begin
            if (is_pix) begin
                in_col_next  = in_col_last ? '0 : in_col_reg + CW'(1);
                pending_next = emit ? pending_reg : pend_inc;
            end else if (emit) begin
                pending_next = pending_reg - PW'(1);
            end
            if (emit) begin
                if (out_last) begin
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (col_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    // ---------------- line memory ----------------
    lm_req_t lm_req;
    col_t    lm_col;

    assign lm_req = '{valid: accept, is_pix: is_pix, pixel: s_tdata};

    lbpz_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (lm_req),
        .req_addr (rd_addr),
        .col_out  (lm_col)
    );

    // ---------------- stage 1: window and code ----------------
    logic              s1_valid_reg, s1_emit_reg;
    logic              s1_pix_reg, s1_last_reg;
    pixel_t            s1_pixel_reg;
    logic [CODE_W-1:0] s1_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= is_pix;
            s1_pixel_reg <= s_tdata;
            s1_mask_reg  <= mask;
            s1_last_reg  <= out_last;
        end
    end

    // win_in follows arrivals (newest pixel bottom right); win_out is the window
    // of the last code and steps one column on a flush
    win_t   win_in_reg, win_out_reg;
    win_t   win_in_shift, win_out_shift, win_sel;
    pixel_t new_col [3];
    res_t   res_push;

    always_comb begin
        new_col[0] = lm_col.top;
        new_col[1] = lm_col.mid;
        new_col[2] = s1_pixel_reg;   // meaningless on a flush, masked off there
        for (int r = 0; r < 3; r++) begin
            win_in_shift[r][0]  = win_in_reg[r][1];
            win_in_shift[r][1]  = win_in_reg[r][2];
            win_in_shift[r][2]  = new_col[r];
            win_out_shift[r][0] = win_out_reg[r][1];
            win_out_shift[r][1] = win_out_reg[r][2];
            win_out_shift[r][2] = new_col[r];
        end
        win_sel = s1_pix_reg ? win_in_shift : win_out_shift;
        res_push.code = lbp_code(win_sel, s1_mask_reg);
        res_push.last = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_pix_reg) begin
            win_in_reg <= win_in_shift;
        end
        if (s1_emit_reg) begin
            win_out_reg <= win_sel;
        end
    end

    // ---------------- result queue ----------------
    res_t                 fifo_data;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W:0]   in_flight;

    lbpz_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_emit_reg),
        .push_data (res_push),
        .pop       (m_tvalid && m_tready),
        .out_valid (m_tvalid),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign m_tdata = fifo_data.code;
    assign m_tlast = fifo_data.last;

    // a new word may add one code; keep room for it and the one in stage 1
    assign in_flight = (OUT_CNT_W+1)'(fifo_count) + (OUT_CNT_W+1)'(s1_emit_reg);
    assign s_tready  = (in_flight < (OUT_CNT_W+1)'(OUT_DEPTH));

endmodule

FILE: sv/lbpz_line_mem.sv
// Two-row line memory indexed by column, read-modify-write with forwarding.
module lbpz_line_mem #(
    parameter int MAX_WIDTH = lbpz_pkg::DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lbpz_pkg::lm_req_t            req,
    input  logic [$clog2(MAX_WIDTH)-1:0] req_addr,
    output lbpz_pkg::col_t               col_out
);
    import lbpz_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    col_t           mem_arr [MAX_WIDTH];
    col_t           rd_col_reg;
    logic           wr_en_reg;
    logic [AW-1:0]  wr_addr_reg;
    pixel_t         wr_pixel_reg;
    col_t           wr_data;
    logic           fwd;

    // new pixel becomes "one row back", old one-row-back moves to "two rows back"
    assign wr_data = '{top: rd_col_reg.mid, mid: wr_pixel_reg};
    assign fwd     = wr_en_reg && (wr_addr_reg == req_addr);
    assign col_out = rd_col_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_reg) begin
            mem_arr[wr_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            rd_col_reg <= fwd ? wr_data : mem_arr[req_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_en_reg <= 1'b0;
        end else begin
            wr_en_reg <= req.valid && req.is_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            wr_addr_reg  <= req_addr;
            wr_pixel_reg <= req.pixel;
        end
    end

endmodule

FILE: sv/lbpz_out_fifo.sv
// Small register queue that holds finished codes until the sink takes them.
module lbpz_out_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  lbpz_pkg::res_t                  push_data,
    input  logic                            pop,
    output logic                            out_valid,
    output lbpz_pkg::res_t                  out_data,
    output logic [lbpz_pkg::OUT_CNT_W-1:0]  count
);
    import lbpz_pkg::*;

    res_t                 q_arr [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_arr[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + OUT_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_arr[wr_ptr_reg] <= push_data;
        end
    end

endmodule
